// ----- sv/wil_pkg.sv -----
// shared types and constants for the wrapping indexed list
package wil_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int OP_W = 2;
	localparam int POS_W = 16;
	localparam int DATA_W = 32;
	localparam int LEN_W = 7;
	localparam int ST_W = 2;
	localparam int DIV_CW = $clog2(POS_W);

	typedef enum logic [OP_W-1:0] {
		OP_READ = 2'd0,
		OP_WRITE = 2'd1,
		OP_APPEND = 2'd2,
		OP_REMOVE = 2'd3
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_DONE = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL = 2'd2
	} stat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_DIV,
		S_OP,
		S_RDWAIT,
		S_SHIFT,
		S_RESP
	} state_t;

	typedef struct packed {
		logic capture;
		logic set_res;
		stat_t res_status;
		logic div_init;
		logic div_step;
		logic rd_idx;
		logic wr_idx;
		logic append_wr;
		logic shift_init;
		logic shift_step;
		logic count_dec;
		logic cap_rdata;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		op_t op;
		logic empty;
		logic full;
		logic div_last;
		logic shift_done;
	} sts_t;

endpackage

// ----- sv/wrapping_indexed_list.sv -----
// wrapping indexed list: top level joining controller and datapath
// append and requests on an empty list go from decode straight to the result
// read and write first run the 16-step position mod count unit
// remove runs the same unit, then one element moved per cycle through the store
// one request in flight, next taken the cycle after the result loads; waits while out is held
// reset clears the count and handshake state; the element store is not cleared
module wrapping_indexed_list #(
	parameter int CAPACITY = wil_pkg::CAPACITY_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [wil_pkg::OP_W-1:0] opcode,
	input logic [wil_pkg::POS_W-1:0] position,
	input logic signed [wil_pkg::DATA_W-1:0] data_in,
	output logic out_valid,
	input logic out_ready,
	output logic signed [wil_pkg::DATA_W-1:0] data_out,
	output logic [wil_pkg::LEN_W-1:0] length,
	output logic is_empty,
	output logic [wil_pkg::ST_W-1:0] status
);
	import wil_pkg::*;

	cmd_t cmd;
	sts_t sts;

	wil_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd(cmd),
		.sts(sts)
	);

	wil_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.opcode(opcode),
		.position(position),
		.data_in(data_in),
		.cmd(cmd),
		.sts(sts),
		.data_out(data_out),
		.length(length),
		.is_empty(is_empty),
		.status(status)
	);

endmodule

// ----- sv/wil_ram.sv -----
// generic single write port, single read port ram with registered read
module wil_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/wil_ctrl.sv -----
// controller state machine for the wrapping indexed list
module wil_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	output wil_pkg::cmd_t cmd,
	input wil_pkg::sts_t sts
);
	import wil_pkg::*;

	state_t state_q;
	state_t state_next;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_next = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.op == OP_APPEND || sts.empty) begin
					state_next = S_RESP;
				end else begin
					state_next = S_DIV;
				end
			end
			S_DIV: begin
				if (sts.div_last) begin
					state_next = S_OP;
				end
			end
			S_OP: begin
				case (sts.op)
					OP_READ: state_next = S_RDWAIT;
					OP_REMOVE: state_next = S_SHIFT;
					default: state_next = S_RESP;
				endcase
			end
			S_RDWAIT: state_next = S_RESP;
			S_SHIFT: begin
				if (sts.shift_done) begin
					state_next = S_RESP;
				end
			end
			S_RESP: begin
				if (out_free) begin
					state_next = S_IDLE;
				end
			end
			default: state_next = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.res_status = ST_DONE;
		case (state_q)
			S_IDLE: begin
				cmd.capture = in_valid;
			end
			S_DECODE: begin
				cmd.set_res = 1'b1;
				if (sts.op == OP_APPEND) begin
					if (sts.full) begin
						cmd.res_status = ST_FULL;
					end else begin
						cmd.append_wr = 1'b1;
					end
				end else if (sts.empty) begin
					cmd.res_status = (sts.op == OP_READ) ? ST_DONE : ST_EMPTY;
				end else begin
					cmd.div_init = 1'b1;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
			end
			S_OP: begin
				case (sts.op)
					OP_READ: cmd.rd_idx = 1'b1;
					OP_WRITE: cmd.wr_idx = 1'b1;
					OP_REMOVE: cmd.shift_init = 1'b1;
					default: cmd.rd_idx = 1'b0;
				endcase
			end
			S_RDWAIT: begin
				cmd.cap_rdata = 1'b1;
			end
			S_SHIFT: begin
				if (sts.shift_done) begin
					cmd.count_dec = 1'b1;
				end else begin
					cmd.shift_step = 1'b1;
				end
			end
			S_RESP: begin
				cmd.load_out = out_free;
			end
			default: cmd.load_out = 1'b0;
		endcase
	end

endmodule

// ----- sv/wil_dp.sv -----
// datapath: element store, count, index remainder unit and result registers
module wil_dp #(
	parameter int CAPACITY = wil_pkg::CAPACITY_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic [wil_pkg::OP_W-1:0] opcode,
	input logic [wil_pkg::POS_W-1:0] position,
	input logic signed [wil_pkg::DATA_W-1:0] data_in,
	input wil_pkg::cmd_t cmd,
	output wil_pkg::sts_t sts,
	output logic signed [wil_pkg::DATA_W-1:0] data_out,
	output logic [wil_pkg::LEN_W-1:0] length,
	output logic is_empty,
	output logic [wil_pkg::ST_W-1:0] status
);
	import wil_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	op_t op_q;
	logic [POS_W-1:0] pos_q;
	logic signed [DATA_W-1:0] data_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rem_q;
	logic [DIV_CW-1:0] div_cnt_q;
	logic [CW-1:0] rd_ptr_q;
	logic pend_q;
	logic [AW-1:0] waddr_q;
	logic signed [DATA_W-1:0] res_data_q;
	stat_t res_status_q;
	logic signed [DATA_W-1:0] data_out_q;
	logic [LEN_W-1:0] length_q;
	logic is_empty_q;
	stat_t status_q;

	logic [CW:0] trial;
	logic [CW:0] cnt_ext;
	logic [CW:0] diff;
	logic [CW-1:0] rem_next;
	logic [AW-1:0] idx;
	logic [CW-1:0] rd_ptr_m1;
	logic rd_more;
	logic [CW+LEN_W-1:0] len_ext;

	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	// one quotient bit per cycle of position mod count
	assign trial = {rem_q, pos_q[POS_W-1]};
	assign cnt_ext = {1'b0, count_q};
	assign diff = trial - cnt_ext;
	assign rem_next = (trial >= cnt_ext) ? diff[CW-1:0] : trial[CW-1:0];

	assign idx = rem_q[AW-1:0];
	assign rd_ptr_m1 = rd_ptr_q - 1'b1;
	assign rd_more = (rd_ptr_q < count_q);
	assign len_ext = {{LEN_W{1'b0}}, count_q};

	assign sts.op = op_q;
	assign sts.empty = (count_q == '0);
	assign sts.full = (count_q == CW'(CAPACITY));
	assign sts.div_last = (div_cnt_q == '0);
	assign sts.shift_done = !rd_more && !pend_q;

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = data_q;
		ram_raddr = '0;
		if (cmd.append_wr) begin
			ram_we = 1'b1;
		end else if (cmd.wr_idx) begin
			ram_we = 1'b1;
			ram_waddr = idx;
		end else if (cmd.shift_step && pend_q) begin
			ram_we = 1'b1;
			ram_waddr = waddr_q;
			ram_wdata = ram_rdata;
		end
		if (cmd.rd_idx) begin
			ram_raddr = idx;
		end else if (cmd.shift_step) begin
			ram_raddr = rd_ptr_q[AW-1:0];
		end
	end

	wil_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pend_q <= 1'b0;
		end else begin
			if (cmd.append_wr) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.count_dec) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.shift_init) begin
				pend_q <= 1'b0;
			end else if (cmd.shift_step) begin
				pend_q <= rd_more;
			end
		end
	end

	always_ff @(posedge clk) begin
		// input word capture
		if (cmd.capture) begin
			op_q <= op_t'(opcode);
			pos_q <= position;
			data_q <= data_in;
		end else if (cmd.div_step) begin
			pos_q <= {pos_q[POS_W-2:0], 1'b0};
		end
		if (cmd.div_init) begin
			rem_q <= '0;
			div_cnt_q <= DIV_CW'(POS_W - 1);
		end else if (cmd.div_step) begin
			rem_q <= rem_next;
			div_cnt_q <= div_cnt_q - 1'b1;
		end
		// pull later elements forward, read one ahead of the write
		if (cmd.shift_init) begin
			rd_ptr_q <= rem_q + 1'b1;
		end else if (cmd.shift_step && rd_more) begin
			rd_ptr_q <= rd_ptr_q + 1'b1;
			waddr_q <= rd_ptr_m1[AW-1:0];
		end
		if (cmd.set_res) begin
			res_data_q <= '0;
			res_status_q <= cmd.res_status;
		end else if (cmd.cap_rdata) begin
			res_data_q <= signed'(ram_rdata);
		end
		if (cmd.load_out) begin
			data_out_q <= res_data_q;
			length_q <= len_ext[LEN_W-1:0];
			is_empty_q <= (count_q == '0);
			status_q <= res_status_q;
		end
	end

	assign data_out = data_out_q;
	assign length = length_q;
	assign is_empty = is_empty_q;
	assign status = status_q;

endmodule

// ----- tb/tb_wrapping_indexed_list.sv -----
// testbench for wrapping_indexed_list: directed and random requests checked against a list model
module tb_wrapping_indexed_list;
	import wil_pkg::*;

	localparam int CAP = 64;
	localparam int PHASE_WORDS = 300;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 100;
	localparam int ERR_PRINT_MAX = 40;

	typedef enum int {EP_MIX, EP_FILL, EP_DRAIN, EP_NEAR} episode_t;

	typedef struct packed {
		op_t op;
		logic [POS_W-1:0] pos;
		logic signed [DATA_W-1:0] data;
	} list_req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic [LEN_W-1:0] len;
		logic empty;
		stat_t st;
	} list_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [OP_W-1:0] opcode = '0;
	logic [POS_W-1:0] position = '0;
	logic signed [DATA_W-1:0] data_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [DATA_W-1:0] data_out;
	logic [LEN_W-1:0] length;
	logic is_empty;
	logic [ST_W-1:0] status;

	wrapping_indexed_list #(.CAPACITY(CAP)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.position(position),
		.data_in(data_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.data_out(data_out),
		.length(length),
		.is_empty(is_empty),
		.status(status)
	);

	always #2 clk = ~clk;

	// list model
	logic signed [DATA_W-1:0] list_store [CAP];
	int list_count = 0;

	list_req_t req_q[$];
	list_reply_t reply_q[$];
	list_req_t next_req;
	list_req_t taken_req;
	list_reply_t want;

	int gen_count = 0;
	int sent_total = 0;
	int reply_seen = 0;
	int err_cnt = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic want_hold = 1'b0;
	logic hold_done;
	int hold_left;
	int quiet_cycles;

	function automatic list_reply_t list_apply(list_req_t r);
		list_reply_t rep;
		int idx;
		rep.value = '0;
		rep.st = ST_DONE;
		if (r.op == OP_APPEND) begin
			if (list_count >= CAP) begin
				rep.st = ST_FULL;
			end else begin
				list_store[list_count] = r.data;
				list_count++;
			end
		end else if (list_count == 0) begin
			if (r.op != OP_READ)
				rep.st = ST_EMPTY;
		end else begin
			idx = int'(r.pos) % list_count;
			case (r.op)
				OP_READ: rep.value = list_store[idx];
				OP_WRITE: list_store[idx] = r.data;
				default: begin
					for (int k = idx; k + 1 < list_count; k++)
						list_store[k] = list_store[k + 1];
					list_count--;
				end
			endcase
		end
		rep.len = LEN_W'(list_count);
		rep.empty = (list_count == 0);
		return rep;
	endfunction

	task automatic push_req(op_t op, int pos, int data);
		list_req_t r;
		r.op = op;
		r.pos = POS_W'(pos);
		r.data = DATA_W'(data);
		req_q.insert(req_q.size(), r);
		if (op == OP_APPEND && gen_count < CAP)
			gen_count++;
		else if (op == OP_REMOVE && gen_count > 0)
			gen_count--;
		sent_total++;
	endtask

	task automatic run_episode(episode_t kind);
		int n;
		int r;
		case (kind)
			EP_FILL: begin
				while (gen_count < CAP) begin
					r = $urandom_range(0, 9);
					if (r < 8)
						push_req(OP_APPEND, $urandom, $urandom);
					else
						push_req(r == 8 ? OP_READ : OP_WRITE, $urandom, $urandom);
				end
				n = $urandom_range(1, 3);
				repeat (n) push_req(OP_APPEND, $urandom, $urandom);
				push_req(OP_READ, $urandom, $urandom);
			end
			EP_DRAIN: begin
				while (gen_count > 0) begin
					r = $urandom_range(0, 9);
					if (r < 6)
						push_req(OP_REMOVE, $urandom, $urandom);
					else
						push_req(r < 8 ? OP_READ : OP_WRITE, $urandom, $urandom);
				end
				push_req(OP_WRITE, $urandom, $urandom);
				push_req(OP_REMOVE, $urandom, $urandom);
				push_req(OP_READ, $urandom, $urandom);
			end
			EP_NEAR: begin
				n = $urandom_range(8, 30);
				repeat (n)
					push_req(op_t'($urandom_range(0, 3)),
						$urandom_range(0, 2 * gen_count + 1), $urandom);
			end
			default: begin
				n = $urandom_range(8, 30);
				repeat (n) push_req(op_t'($urandom_range(0, 3)), $urandom, $urandom);
			end
		endcase
	endtask

	task automatic report_field(string field, logic signed [63:0] expv,
			logic signed [63:0] gotv);
		err_cnt++;
		if (err_cnt <= ERR_PRINT_MAX)
			$error("%s: expected %0d, got %0d", field, expv, gotv);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode <= '0;
			position <= '0;
			data_in <= '0;
		end else begin
			if (in_valid && in_ready) begin
				taken_req.op = op_t'(opcode);
				taken_req.pos = position;
				taken_req.data = data_in;
				reply_q.insert(reply_q.size(), list_apply(taken_req));
			end
			if (!in_valid || in_ready) begin
				if (req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_req = req_q.pop_front();
					in_valid <= 1'b1;
					opcode <= next_req.op;
					position <= next_req.pos;
					data_in <= next_req.data;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				reply_seen <= reply_seen + 1;
				if (reply_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= ERR_PRINT_MAX)
						$error("result word with no request pending");
				end else begin
					want = reply_q.pop_front();
					if (data_out !== want.value)
						report_field("data_out", 64'(want.value), 64'(data_out));
					if (length !== want.len)
						report_field("length", 64'(want.len), 64'(length));
					if (is_empty !== want.empty)
						report_field("is_empty", 64'(want.empty), 64'(is_empty));
					if (status !== want.st)
						report_field("status", 64'(want.st), 64'(status));
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (want_hold && !hold_done) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// watchdog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("** wrapping_indexed_list: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		int phase_base;
		int ep;
		int r;
		episode_t kind;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1) ? 60 : (ph == 3) ? 22 : 0;
			recv_stall_pct = (ph == 2) ? 60 : (ph == 3) ? 22 : 0;
			phase_base = sent_total;
			if (ph == 0) begin
				// empty list cases
				push_req(OP_READ, 0, 0);
				push_req(OP_READ, 16'hffff, 0);
				push_req(OP_WRITE, 3, 32'h12345678);
				push_req(OP_REMOVE, 5, 0);
				// data extremes
				push_req(OP_APPEND, 16'hffff, 32'h7fffffff);
				push_req(OP_APPEND, 0, 32'h80000000);
				push_req(OP_APPEND, 0, 0);
				push_req(OP_APPEND, 0, -1);
				push_req(OP_APPEND, 0, 32'h55555555);
				// position wraps modulo the count
				push_req(OP_READ, 0, 0);
				push_req(OP_READ, 16'hffff, 0);
				push_req(OP_READ, 3, 0);
				push_req(OP_WRITE, 16'h8000, 32'haaaaaaaa);
				push_req(OP_READ, 3, -1);
				// remove at head, tail and wrapped index
				push_req(OP_REMOVE, 0, 0);
				push_req(OP_READ, 0, 0);
				push_req(OP_REMOVE, 3, 0);
				push_req(OP_REMOVE, 16'hffff, 0);
				push_req(OP_READ, 1, 0);
				push_req(OP_REMOVE, 1, 0);
				push_req(OP_REMOVE, 7, 0);
				push_req(OP_READ, 16'h1234, 0);
				push_req(OP_APPEND, 0, 32'hdeadbeef);
				push_req(OP_READ, 12345, 0);
			end
			ep = 0;
			while (sent_total - phase_base < PHASE_WORDS) begin
				r = $urandom_range(0, 9);
				if (ep == 0)
					kind = EP_FILL;
				else
					kind = (r < 3) ? EP_FILL : (r < 6) ? EP_DRAIN : (r < 8) ? EP_NEAR : EP_MIX;
				run_episode(kind);
				ep++;
			end
			// long receiver hold-off while requests keep coming
			if (ph == 0)
				want_hold = 1'b1;
			while (req_q.size() != 0) @(posedge clk);
		end
		while (reply_seen < sent_total) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (reply_q.size() != 0)
			$error("%0d expected result words never arrived", reply_q.size());
		if (err_cnt == 0 && reply_q.size() == 0)
			$display("** wrapping_indexed_list: PASSED **");
		else
			$display("** wrapping_indexed_list: FAILED **");
		$finish;
	end

endmodule
